[rtl/core/fms_pkg.sv]
// shared constants, types and helper functions of the fuzzy match scorer
package fms_pkg;

    // pattern geometry
    localparam int MAX_PATTERN = 16;
    localparam int PAT_SLOTS   = 16;
    localparam int SLOT_IDX_W  = 4;
    localparam int LEN_W       = 5;

    // string length saturation
    localparam int LCOUNT_W   = 7;
    localparam int LENGTH_CAP = 100;

    // score arithmetic
    localparam int SCORE_W = 11;
    localparam logic [SCORE_W-1:0] SCORE_MATCH    = 11'd10;
    localparam logic [SCORE_W-1:0] SCORE_STREAK   = 11'd15;
    localparam logic [SCORE_W-1:0] SCORE_BOUNDARY = 11'd20;
    localparam logic [SCORE_W-1:0] SCORE_UPPER    = 11'd10;
    localparam logic [SCORE_W-1:0] SCORE_CONTIG   = 11'd50;
    localparam logic [SCORE_W-1:0] SCORE_EMPTY    = 11'd1;
    localparam logic [SCORE_W-1:0] SCORE_NONE     = 11'd0;

    // separator and case-folding characters
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_CHARS_LOW      = 2'd1,
        REG_CHARS_HIGH     = 2'd2
    } fms_reg_t;

    // per-byte compare result handed to the scoring stage
    typedef struct packed {
        logic [PAT_SLOTS-1:0] eq;
        logic [LEN_W-1:0]     len;
    } fms_match_t;

    function automatic logic fms_is_upper(input logic [7:0] c);
        return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
    endfunction

    function automatic logic [7:0] fms_fold(input logic [7:0] c);
        return fms_is_upper(c) ? (c + CASE_OFFSET) : c;
    endfunction

endpackage

[rtl/core/fuzzy_match_scorer_core.sv]
// top level of the fuzzy match scorer: config registers, input and result stages
//
// Usage:
//   Write pattern_length (index 0), pattern_chars_low (index 1) and
//   pattern_chars_high (index 2) through cfg_we/cfg_index/cfg_data while idle.
//   Stream one candidate string a byte per input beat (ch, last) on
//   in_valid/in_ready; last marks the final byte. One score beat comes out on
//   out_valid/out_ready for each string, after its last byte.
//   A last byte passes through the input register, then its score is
//   registered in the result register, where it waits for out_ready.
//   Throughput: one byte per cycle while no last byte is held (see Stall);
//   the per-byte compare and score update form a single registered step.
//   Stall: while a score waits in the result register, bytes that are not
//   last keep flowing; a last byte holds in the input register until the
//   waiting score is taken, and in_ready stays low while it holds.
//   Reset: clears the pattern registers (empty pattern, score 1 for every
//   string), the string state, and the valid flags of both pipeline registers.
module fuzzy_match_scorer_core
    import fms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SCORE_W-1:0]    score
);

    logic [LEN_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] chars_low_reg;
    logic [CFG_DATA_W-1:0] chars_high_reg;

    logic                  in_valid_reg;
    logic [7:0]            ch_reg;
    logic                  last_reg;

    logic                  out_valid_reg;
    logic [SCORE_W-1:0]    score_reg;

    logic                  advance;
    fms_match_t            match;
    logic [SCORE_W-1:0]    score_value;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            chars_low_reg      <= '0;
            chars_high_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_CHARS_LOW:      chars_low_reg      <= cfg_data;
                REG_CHARS_HIGH:     chars_high_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // a held byte moves on unless it closes a string and the result slot is busy
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    fms_match u_match (
        .ch             (ch_reg),
        .pattern_length (pattern_length_reg),
        .chars_low      (chars_low_reg),
        .chars_high     (chars_high_reg),
        .match          (match)
    );

    fms_score u_score (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .ch          (ch_reg),
        .last        (last_reg),
        .match       (match),
        .score_value (score_value)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            score_reg <= score_value;
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;

endmodule

[rtl/core/fms_match.sv]
// case-folded compare of one string byte against every pattern slot
module fms_match
    import fms_pkg::*;
(
    input  logic [7:0]            ch,
    input  logic [LEN_W-1:0]      pattern_length,
    input  logic [CFG_DATA_W-1:0] chars_low,
    input  logic [CFG_DATA_W-1:0] chars_high,
    output fms_match_t            match
);

    logic [2*CFG_DATA_W-1:0] chars_all;
    logic [7:0]              ch_fold;
    logic [LEN_W-1:0]        len_clamped;

    assign chars_all = {chars_high, chars_low};
    assign ch_fold   = fms_fold(ch);

    // lengths above the slot count act as a full pattern
    assign len_clamped = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                                : pattern_length;

    // one equality per slot, masked to the active length
    always_comb
    begin
        match.len = len_clamped;
        for (int j = 0; j < PAT_SLOTS; j++)
        begin
            match.eq[j] = (LEN_W'(j) < len_clamped) &&
                          (fms_fold(chars_all[j*8 +: 8]) == ch_fold);
        end
    end

endmodule

[rtl/core/fms_score.sv]
// per-string scoring state and final score value
module fms_score
    import fms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         ch,
    input  logic               last,
    input  fms_match_t         match,
    output logic [SCORE_W-1:0] score_value
);

    logic [LEN_W-1:0]     matched_count_reg, matched_count_next;
    logic [SCORE_W-1:0]   score_acc_reg, score_acc_next;
    logic                 prev_matched_reg, prev_matched_next;
    logic                 prev_separator_reg, prev_separator_next;
    logic                 at_string_start_reg, at_string_start_next;
    logic [LCOUNT_W-1:0]  length_count_reg, length_count_next;
    logic [PAT_SLOTS-1:0] substring_vector_reg, substring_vector_next;
    logic                 substring_found_reg, substring_found_next;

    logic                 incomplete;
    logic                 hit;
    logic [SCORE_W-1:0]   add;
    logic [LEN_W-1:0]     len_m1;
    logic [LCOUNT_W-1:0]  remaining;

    // greedy subsequence step
    assign incomplete = matched_count_reg < match.len;
    assign hit        = incomplete && match.eq[matched_count_reg[SLOT_IDX_W-1:0]];
    assign len_m1     = match.len - LEN_W'(1);

    // bonus for this byte
    always_comb
    begin
        add = SCORE_MATCH;
        if (prev_matched_reg)
            add = add + SCORE_STREAK;
        if (at_string_start_reg || prev_separator_reg)
            add = add + SCORE_BOUNDARY;
        if (fms_is_upper(ch))
            add = add + SCORE_UPPER;
    end

    // state after this byte
    always_comb
    begin
        matched_count_next    = matched_count_reg + LEN_W'(hit);
        score_acc_next        = hit ? (score_acc_reg + add) : score_acc_reg;
        prev_matched_next     = incomplete ? hit : prev_matched_reg;
        substring_vector_next = {substring_vector_reg[PAT_SLOTS-2:0], 1'b1} & match.eq;
        substring_found_next  = substring_found_reg ||
                                ((match.len != '0) &&
                                 substring_vector_next[len_m1[SLOT_IDX_W-1:0]]);
        length_count_next     = (length_count_reg < LCOUNT_W'(LENGTH_CAP))
                                ? (length_count_reg + LCOUNT_W'(1)) : length_count_reg;
        prev_separator_next   = (ch == CHAR_SPACE) || (ch == CHAR_UNDERSCORE) ||
                                (ch == CHAR_SLASH);
        at_string_start_next  = 1'b0;
    end

    // final score, from the state including this byte
    assign remaining = LCOUNT_W'(LENGTH_CAP) - length_count_next;

    always_comb
    begin
        if (match.len == '0)
            score_value = SCORE_EMPTY;
        else if (matched_count_next < match.len)
            score_value = SCORE_NONE;
        else
            score_value = score_acc_next + SCORE_W'(remaining) +
                          (substring_found_next ? SCORE_CONTIG : SCORE_NONE);
    end

    // state registers, cleared at the end of each string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_count_reg    <= '0;
            score_acc_reg        <= '0;
            prev_matched_reg     <= 1'b0;
            prev_separator_reg   <= 1'b0;
            at_string_start_reg  <= 1'b1;
            length_count_reg     <= '0;
            substring_vector_reg <= '0;
            substring_found_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (last)
            begin
                matched_count_reg    <= '0;
                score_acc_reg        <= '0;
                prev_matched_reg     <= 1'b0;
                prev_separator_reg   <= 1'b0;
                at_string_start_reg  <= 1'b1;
                length_count_reg     <= '0;
                substring_vector_reg <= '0;
                substring_found_reg  <= 1'b0;
            end
            else
            begin
                matched_count_reg    <= matched_count_next;
                score_acc_reg        <= score_acc_next;
                prev_matched_reg     <= prev_matched_next;
                prev_separator_reg   <= prev_separator_next;
                at_string_start_reg  <= at_string_start_next;
                length_count_reg     <= length_count_next;
                substring_vector_reg <= substring_vector_next;
                substring_found_reg  <= substring_found_next;
            end
        end
    end

endmodule

[rtl/core/fms_checker.sv]
// port-level assertions for the fuzzy match scorer and their bind
module fms_checker
    import fms_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [7:0]            ch,
    input logic                  last,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [SCORE_W-1:0]    score
);

    // a stalled score beat stays and holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(score))
        else $error("score beat dropped or changed while stalled");

    // with the result slot empty the block always takes a byte
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

    // scores stay within the reachable range
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> score <= 11'd1030)
        else $error("score out of range");

    // no result beat during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result beat during reset");

endmodule

bind fuzzy_match_scorer_core fms_checker u_fms_checker (.*);
